### src/dlpd_pkg.sv
// Package with shared types, constants and codes of the decimal length-prefixed deframer.
package dlpd_pkg;

    // Width of the length value; the parsed length saturates at its maximum.
    localparam int LENGTH_BITS = 32;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // Width of the frame counter and of the wide output fields.
    localparam int COUNT_BITS = 32;

    // Header parser phases.
    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_IGNORE = 2'd3;

    // Byte values of the framing and of the codestream marks.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] MARK_FF    = 8'hFF;
    localparam logic [7:0] MARK_SOC   = 8'h4F;
    localparam logic [7:0] MARK_SIZ   = 8'h51;
    localparam logic [7:0] MARK_EOC   = 8'hD9;

    // Number of head marks and the shortest frame that can hold all marks.
    localparam logic [2:0] HEAD_MARKS = 3'd4;
    localparam int         MIN_FRAME  = 6;

    // Head mark expected at a given position of the payload.
    function automatic logic [7:0] head_mark(input logic [1:0] pos);
        logic [7:0] mark;
        case (pos)
            2'd0: mark = MARK_FF;
            2'd1: mark = MARK_SOC;
            2'd2: mark = MARK_FF;
            default: mark = MARK_SIZ;
        endcase
        return mark;
    endfunction

    // One input word as held in the input register.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [7:0]            out_byte;
        logic [COUNT_BITS-1:0] frame_number;
        logic                  last_of_frame;
        logic [COUNT_BITS-1:0] frame_length;
        logic                  marks_ok;
        logic                  end_marker;
    } t_result;

    // What the core hands to the output side for the word it is looking at.
    typedef struct packed {
        logic    has_result;
        t_result result;
    } t_core_out;

endpackage

### src/dlpd_in_stage.sv
// Input register of the deframer: holds one accepted word until the core consumes it.
module dlpd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dlpd_pkg::t_in_word i_word,
    input  logic              i_take,
    output logic              o_held,
    output dlpd_pkg::t_in_word o_word
);

    logic               r_held;
    dlpd_pkg::t_in_word r_word;

    // Room for a new word when empty or when the held word leaves this cycle.
    assign o_ready = !r_held || i_take;
    assign o_held  = r_held;
    assign o_word  = r_word;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (o_ready) begin
            r_held <= i_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

### src/dlpd_core.sv
// Header parser, frame tracker and mark checker of the deframer.
module dlpd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dlpd_pkg::t_in_word  i_word,
    input  logic                i_advance,
    output dlpd_pkg::t_core_out o_out
);

    localparam int LB = dlpd_pkg::LENGTH_BITS;
    localparam int CB = dlpd_pkg::COUNT_BITS;

    logic          r_in_payload,    n_in_payload;
    logic [1:0]    r_phase,         n_phase;
    logic          r_negative,      n_negative;
    logic [LB-1:0] r_acc,           n_acc;
    logic [LB-1:0] r_declared,      n_declared;
    logic [LB-1:0] r_bytes_left,    n_bytes_left;
    logic [2:0]    r_head_pos,      n_head_pos;
    logic          r_head_ok,       n_head_ok;
    logic [7:0]    r_prev,          n_prev;
    logic [CB-1:0] r_frame_count,   n_frame_count;

    logic          is_digit;
    logic          is_space;
    logic [1:0]    phase_mid;
    logic [LB+3:0] acc_times10;
    logic          head_ok_now;
    logic          last;
    logic [7:0]    c;

    assign c        = i_word.in_byte;
    assign is_digit = (c >= dlpd_pkg::CH_ZERO) && (c <= dlpd_pkg::CH_NINE);
    assign is_space = (c == dlpd_pkg::CH_SPACE) ||
                      ((c >= dlpd_pkg::CH_TAB) && (c <= dlpd_pkg::CH_CR));

    // Accumulator times ten plus the digit, before saturation.
    assign acc_times10 = ((LB+4)'(r_acc) << 3) + ((LB+4)'(r_acc) << 1)
                       + (LB+4)'(c - dlpd_pkg::CH_ZERO);

    assign last = (r_bytes_left <= LB'(1));

    // Head mark check including the current byte.
    always_comb begin
        head_ok_now = r_head_ok;
        if (r_head_pos < dlpd_pkg::HEAD_MARKS) begin
            if (c != dlpd_pkg::head_mark(r_head_pos[1:0])) begin
                head_ok_now = 1'b0;
            end
        end
    end

    // Phase after this header byte.
    always_comb begin
        phase_mid = r_phase;
        case (r_phase)
            dlpd_pkg::PH_SPACE: begin
                if (is_space) begin
                    phase_mid = dlpd_pkg::PH_SPACE;
                end else if (c == dlpd_pkg::CH_PLUS || c == dlpd_pkg::CH_MINUS) begin
                    phase_mid = dlpd_pkg::PH_SIGN;
                end else begin
                    phase_mid = is_digit ? dlpd_pkg::PH_DIGITS : dlpd_pkg::PH_IGNORE;
                end
            end
            dlpd_pkg::PH_SIGN: begin
                phase_mid = is_digit ? dlpd_pkg::PH_DIGITS : dlpd_pkg::PH_IGNORE;
            end
            dlpd_pkg::PH_DIGITS: begin
                phase_mid = is_digit ? dlpd_pkg::PH_DIGITS : dlpd_pkg::PH_IGNORE;
            end
            default: begin
                phase_mid = dlpd_pkg::PH_IGNORE;
            end
        endcase
    end

    // Next state for one word.
    always_comb begin
        n_in_payload  = r_in_payload;
        n_phase       = r_phase;
        n_negative    = r_negative;
        n_acc         = r_acc;
        n_declared    = r_declared;
        n_bytes_left  = r_bytes_left;
        n_head_pos    = r_head_pos;
        n_head_ok     = r_head_ok;
        n_prev        = r_prev;
        n_frame_count = r_frame_count;
        if (i_word.end_of_stream) begin
            // The end marker leaves the state alone.
        end else if (!r_in_payload) begin
            if (c == dlpd_pkg::CH_NEWLINE) begin
                n_frame_count = r_frame_count + CB'(1);
                if (!r_negative && r_acc != '0) begin
                    n_declared   = r_acc;
                    n_bytes_left = r_acc;
                    n_head_pos   = '0;
                    n_head_ok    = 1'b1;
                    n_prev       = '0;
                    n_in_payload = 1'b1;
                end
                n_phase    = dlpd_pkg::PH_SPACE;
                n_negative = 1'b0;
                n_acc      = '0;
            end else begin
                n_phase = phase_mid;
                if (r_phase == dlpd_pkg::PH_SPACE && !is_space &&
                    (c == dlpd_pkg::CH_PLUS || c == dlpd_pkg::CH_MINUS)) begin
                    n_negative = (c == dlpd_pkg::CH_MINUS);
                end
                if (phase_mid == dlpd_pkg::PH_DIGITS) begin
                    if (acc_times10 > (LB+4)'(dlpd_pkg::LEN_MAX)) begin
                        n_acc = dlpd_pkg::LEN_MAX;
                    end else begin
                        n_acc = acc_times10[LB-1:0];
                    end
                end
            end
        end else begin
            if (r_head_pos < dlpd_pkg::HEAD_MARKS) begin
                n_head_pos = r_head_pos + 3'd1;
            end
            n_head_ok = head_ok_now;
            n_prev    = c;
            if (last) begin
                n_bytes_left = '0;
                n_in_payload = 1'b0;
                n_phase      = dlpd_pkg::PH_SPACE;
                n_negative   = 1'b0;
                n_acc        = '0;
            end else begin
                n_bytes_left = r_bytes_left - LB'(1);
            end
        end
    end

    // Result for the current word.
    always_comb begin
        o_out = '0;
        if (i_word.end_of_stream) begin
            o_out.has_result          = 1'b1;
            o_out.result.frame_number = r_frame_count + CB'(1);
            o_out.result.end_marker   = 1'b1;
        end else if (r_in_payload) begin
            o_out.has_result           = 1'b1;
            o_out.result.out_byte      = c;
            o_out.result.frame_number  = r_frame_count;
            o_out.result.last_of_frame = last;
            o_out.result.frame_length  = last ? CB'(r_declared) : '0;
            o_out.result.marks_ok      = last && head_ok_now &&
                                         (r_declared >= LB'(dlpd_pkg::MIN_FRAME)) &&
                                         (r_prev == dlpd_pkg::MARK_FF) &&
                                         (c == dlpd_pkg::MARK_EOC);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload  <= 1'b0;
            r_phase       <= dlpd_pkg::PH_SPACE;
            r_negative    <= 1'b0;
            r_acc         <= '0;
            r_declared    <= '0;
            r_bytes_left  <= '0;
            r_head_pos    <= '0;
            r_head_ok     <= 1'b1;
            r_prev        <= '0;
            r_frame_count <= '0;
        end else if (i_advance) begin
            r_in_payload  <= n_in_payload;
            r_phase       <= n_phase;
            r_negative    <= n_negative;
            r_acc         <= n_acc;
            r_declared    <= n_declared;
            r_bytes_left  <= n_bytes_left;
            r_head_pos    <= n_head_pos;
            r_head_ok     <= n_head_ok;
            r_prev        <= n_prev;
            r_frame_count <= n_frame_count;
        end
    end

endmodule

### src/dlpd_out_stage.sv
// Output register of the deframer: holds one result word until it is taken.
module dlpd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  dlpd_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output dlpd_pkg::t_result o_result
);

    logic              r_valid;
    dlpd_pkg::t_result r_result;

    // The slot can take a word when empty or when its word leaves this cycle.
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

endmodule

### src/decimal_length_prefixed_deframer.sv
// Top level of the decimal length-prefixed deframer.
// Path: input register, core (a single state update pass per word), output register.
// Throughput: one word per cycle unless the output stalls.
// A stalled output holds the core, and the input register then fills and drops ready.
// Reset is synchronous and active low; it clears both stage flags and the parser state.
module decimal_length_prefixed_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_frame_number,
    output logic        o_last_of_frame,
    output logic [31:0] o_frame_length,
    output logic        o_marks_ok,
    output logic        o_end_marker
);

    dlpd_pkg::t_in_word  in_word;
    dlpd_pkg::t_in_word  held_word;
    dlpd_pkg::t_core_out core_out;
    dlpd_pkg::t_result   out_result;
    logic                held;
    logic                out_free;
    logic                advance;

    assign in_word.in_byte       = i_in_byte;
    assign in_word.end_of_stream = i_end_of_stream;

    // A held word moves on unless it makes a result and the output slot is full.
    assign advance = held && (!core_out.has_result || out_free);

    dlpd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (in_word),
        .i_take  (advance),
        .o_held  (held),
        .o_word  (held_word)
    );

    dlpd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_word    (held_word),
        .i_advance (advance),
        .o_out     (core_out)
    );

    dlpd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (held && core_out.has_result),
        .i_result (core_out.result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    // Result fields onto the ports.
    assign o_out_byte      = out_result.out_byte;
    assign o_frame_number  = out_result.frame_number;
    assign o_last_of_frame = out_result.last_of_frame;
    assign o_frame_length  = out_result.frame_length;
    assign o_marks_ok      = out_result.marks_ok;
    assign o_end_marker    = out_result.end_marker;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the decimal length-prefixed deframer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dlpd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    // Largest length that random headers may build up to.
    localparam int HEADER_CAP = 255;
    // Head marks in payload order, first mark in the top byte.
    localparam logic [31:0] HEAD_SEQ = {MARK_FF, MARK_SOC, MARK_FF, MARK_SIZ};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_in_byte = '0;
    logic        i_end_of_stream = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic [31:0] o_frame_number;
    logic        o_last_of_frame;
    logic [31:0] o_frame_length;
    logic        o_marks_ok;
    logic        o_end_marker;

    decimal_length_prefixed_deframer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_frame_number  (o_frame_number),
        .o_last_of_frame (o_last_of_frame),
        .o_frame_length  (o_frame_length),
        .o_marks_ok      (o_marks_ok),
        .o_end_marker    (o_end_marker)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Deframer state as the testbench tracks it.
    logic                   inside_frame = 1'b0;
    logic [1:0]             hdr_phase = PH_SPACE;
    logic                   hdr_minus = 1'b0;
    logic [LENGTH_BITS-1:0] hdr_value = '0;
    logic [LENGTH_BITS-1:0] frame_len = '0;
    logic [LENGTH_BITS-1:0] remaining = '0;
    logic [2:0]             mark_index = '0;
    logic                   marks_good = 1'b1;
    logic [7:0]             last_byte = '0;
    logic [COUNT_BITS-1:0]  frame_count = '0;

    t_result pending_results[$];
    int      mismatch_count = 0;
    int      words_sent = 0;
    int      cycle_count = 0;
    int      src_idle_pct = 0;
    int      sink_idle_pct = 0;
    int      sink_hold = 0;

    // Advance the tracked state by one accepted word and queue any word it produces.
    function automatic void deframe_word(input logic [7:0] b, input logic eos);
        t_result     res;
        logic [63:0] wide;
        logic        digit;
        logic        blank;
        logic        ends;
        res = '0;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        if (eos) begin
            // The end marker leaves every piece of state alone.
            res.frame_number = frame_count + 1'b1;
            res.end_marker = 1'b1;
            pending_results.push_back(res);
        end else if (!inside_frame) begin
            if (b == CH_NEWLINE) begin
                frame_count = frame_count + 1'b1;
                if (!hdr_minus && hdr_value != '0) begin
                    frame_len = hdr_value;
                    remaining = hdr_value;
                    mark_index = '0;
                    marks_good = 1'b1;
                    last_byte = '0;
                    inside_frame = 1'b1;
                end
                hdr_phase = PH_SPACE;
                hdr_minus = 1'b0;
                hdr_value = '0;
            end else begin
                case (hdr_phase)
                    PH_SPACE: begin
                        if (!blank) begin
                            if (b == CH_PLUS || b == CH_MINUS) begin
                                hdr_minus = (b == CH_MINUS);
                                hdr_phase = PH_SIGN;
                            end else begin
                                hdr_phase = digit ? PH_DIGITS : PH_IGNORE;
                            end
                        end
                    end
                    PH_SIGN: hdr_phase = digit ? PH_DIGITS : PH_IGNORE;
                    PH_DIGITS: if (!digit) hdr_phase = PH_IGNORE;
                    default: ;
                endcase
                // Only a digit can leave the parser in the digit phase.
                if (hdr_phase == PH_DIGITS) begin
                    wide = 64'(hdr_value) * 64'd10 + 64'(b - CH_ZERO);
                    hdr_value = (wide > 64'(LEN_MAX)) ? LEN_MAX : wide[LENGTH_BITS-1:0];
                end
            end
        end else begin
            if (mark_index < HEAD_MARKS) begin
                if (b != HEAD_SEQ[31 - 8 * mark_index[1:0] -: 8])
                    marks_good = 1'b0;
                mark_index = mark_index + 1'b1;
            end
            ends = (remaining <= 1);
            res.out_byte = b;
            res.frame_number = frame_count;
            res.last_of_frame = ends;
            res.frame_length = ends ? frame_len : '0;
            res.marks_ok = ends && marks_good && (frame_len >= MIN_FRAME) &&
                           (last_byte == MARK_FF) && (b == MARK_EOC);
            pending_results.push_back(res);
            last_byte = b;
            if (ends) begin
                remaining = '0;
                inside_frame = 1'b0;
                hdr_phase = PH_SPACE;
                hdr_minus = 1'b0;
                hdr_value = '0;
            end else begin
                remaining = remaining - 1'b1;
            end
        end
    endfunction

    // Idle stretch length: mostly short, now and then long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one word, wait for its acceptance, then maybe idle.
    task automatic send_word(input logic [7:0] b, input logic eos);
        int gap;
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (!o_ready);
        deframe_word(b, eos);
        words_sent++;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            gap = idle_length();
            i_valid <= 1'b0;
            i_in_byte <= 8'($urandom);
            i_end_of_stream <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // Stream byte with an occasional end of stream slipped in ahead of it.
    task automatic send_stream_byte(input logic [7:0] b);
        if ($urandom_range(99) < 2)
            send_word(8'($urandom), 1'b1);
        send_word(b, 1'b0);
    endtask

    // Header byte; a digit that would push the length past the cap is swapped
    // for some other non-newline byte so that frames stay short.
    task automatic send_header_byte(input logic [7:0] b);
        logic [7:0] alt;
        alt = b;
        if (alt >= CH_ZERO && alt <= CH_NINE && hdr_phase != PH_IGNORE &&
            64'(hdr_value) * 64'd10 + 64'(alt - CH_ZERO) > 64'(HEADER_CAP)) begin
            do alt = 8'($urandom);
            while ((alt >= CH_ZERO && alt <= CH_NINE) || alt == CH_NEWLINE);
        end
        send_stream_byte(alt);
    endtask

    // One random header, well formed most of the time, and the payload it calls for.
    task automatic send_random_frame();
        int          r;
        int          i;
        int unsigned n;
        string       digits;
        logic [7:0]  b;
        logic        marked;
        r = $urandom_range(99);
        if (r < 12) begin
            // Noise header: arbitrary bytes up to the newline.
            repeat ($urandom_range(1, 8)) begin
                b = 8'($urandom);
                if (b == CH_NEWLINE)
                    b = CH_MINUS;
                send_header_byte(b);
            end
        end else begin
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    r = $urandom_range(5);
                    send_header_byte((r == 5) ? CH_SPACE : CH_TAB + 8'(r));
                end
            end
            r = $urandom_range(99);
            if (r < 20)
                send_header_byte(CH_PLUS);
            else if (r < 28)
                send_header_byte(CH_MINUS);
            if ($urandom_range(3) == 0)
                send_header_byte(CH_ZERO);
            r = $urandom_range(99);
            if (r < 50)
                n = $urandom_range(1, 12);
            else if (r < 85)
                n = $urandom_range(13, 48);
            else if (r < 95)
                n = 0;
            else
                n = $urandom_range(49, 200);
            digits = $sformatf("%0d", n);
            for (i = 0; i < digits.len(); i++)
                send_header_byte(digits[i]);
            // Trailing junk is ignored by the parser from its first non-digit byte on.
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    do b = 8'($urandom);
                    while (b == CH_NEWLINE);
                    send_header_byte(b);
                end
            end
        end
        send_header_byte(CH_NEWLINE);
        if (inside_frame) begin
            n = remaining;
            marked = ($urandom_range(99) < 65);
            for (i = 0; i < n; i++) begin
                b = 8'($urandom);
                if (marked) begin
                    if (i < 4)
                        b = HEAD_SEQ[31 - 8 * i -: 8];
                    if (i == n - 2)
                        b = MARK_FF;
                    if (i == n - 1)
                        b = MARK_EOC;
                    if ($urandom_range(99) < 4)
                        b = 8'($urandom);
                end
                send_stream_byte(b);
            end
        end
    endtask

    // Directed cases: extremes of the fields and the parser's corner cases.
    task automatic test_directed();
        logic [7:0] c;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        // End marker straight after reset carries frame number one.
        send_word(8'($urandom), 1'b1);
        // Minimal frame with both sets of marks intact.
        send_text("6\n");
        send_word(MARK_FF, 1'b0);
        send_word(MARK_SOC, 1'b0);
        send_word(MARK_FF, 1'b0);
        send_word(MARK_SIZ, 1'b0);
        send_word(MARK_FF, 1'b0);
        send_word(MARK_EOC, 1'b0);
        // All white space bytes, a plus sign, a leading zero and trailing junk.
        for (c = CH_TAB; c <= CH_CR; c++)
            send_word(c, 1'b0);
        send_text(" +07x9\n");
        // Frame with a broken first head mark.
        send_word(8'h00, 1'b0);
        send_word(MARK_SOC, 1'b0);
        send_word(MARK_FF, 1'b0);
        send_word(MARK_SIZ, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(MARK_FF, 1'b0);
        send_word(MARK_EOC, 1'b0);
        // Negative, zero and sign-only headers are all dropped.
        send_text("-5\n0\n+-3\n+\n");
        // Bytes FF and 00 in a header end the digits; the short frame fails its marks.
        send_text("3");
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_text("7\n");
        send_word(MARK_FF, 1'b0);
        send_word(MARK_FF, 1'b0);
        send_word(MARK_EOC, 1'b0);
        // Single-byte frame.
        send_text("1\n");
        send_word(8'h00, 1'b0);
        // End markers in the middle of a header and in the middle of a frame.
        send_text("2");
        send_word(8'hFF, 1'b1);
        send_text("\n");
        send_word(8'h55, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'hAA, 1'b0);
    endtask

    // Random frames under several idling patterns on both sides.
    task automatic test_random_frames();
        int seg;
        int stop_at;
        for (seg = 0; seg < 4; seg++) begin
            case (seg)
                0: begin src_idle_pct = 25; sink_idle_pct = 25; end
                1: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
                2: begin src_idle_pct = 5;  sink_idle_pct = 60; end
                default: begin src_idle_pct = 60; sink_idle_pct = 5; end
            endcase
            stop_at = words_sent + 375;
            while (words_sent < stop_at)
                send_random_frame();
        end
    endtask

    // Oversized header saturates the length; the frame then never ends within the run.
    task automatic test_saturated_length();
        src_idle_pct = 20;
        sink_idle_pct = 20;
        send_text(" +4294967296");
        send_text("000\n");
        repeat (24)
            send_stream_byte(8'($urandom));
        send_word(8'($urandom), 1'b1);
    endtask

    // Output side: compare each accepted word and drive ready with random stalls.
    always @(posedge i_clk) begin : result_side
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected word: out_byte %0h end_marker %0b", o_out_byte, o_end_marker);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, o_out_byte);
                    mismatch_count++;
                end
                if (o_frame_number !== want.frame_number) begin
                    $error("frame_number: expected %0d, got %0d",
                           want.frame_number, o_frame_number);
                    mismatch_count++;
                end
                if (o_last_of_frame !== want.last_of_frame) begin
                    $error("last_of_frame: expected %0b, got %0b",
                           want.last_of_frame, o_last_of_frame);
                    mismatch_count++;
                end
                if (o_frame_length !== want.frame_length) begin
                    $error("frame_length: expected %0d, got %0d",
                           want.frame_length, o_frame_length);
                    mismatch_count++;
                end
                if (o_marks_ok !== want.marks_ok) begin
                    $error("marks_ok: expected %0b, got %0b", want.marks_ok, o_marks_ok);
                    mismatch_count++;
                end
                if (o_end_marker !== want.end_marker) begin
                    $error("end_marker: expected %0b, got %0b", want.end_marker, o_end_marker);
                    mismatch_count++;
                end
            end
        end
        if (sink_hold != 0) begin
            sink_hold--;
            i_ready <= 1'b0;
        end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
            sink_hold = idle_length() - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_frames();
        test_saturated_length();
        i_valid <= 1'b0;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // Room for any stray word still in the two-stage pipe.
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
